// ----- rtl/cdf_pkg.sv -----
package cdf_pkg;

    // stream field widths
    localparam int POS_FIELD_W   = 16;
    localparam int GRADE_FIELD_W = 16;
    localparam int S_TDATA_W     = POS_FIELD_W + GRADE_FIELD_W;
    localparam int CEN_W         = 16;
    localparam int M_TDATA_W     = CEN_W;

    // accumulator widths
    localparam int NUM_W = 64;
    localparam int DEN_W = 48;

    // quotient bits below the saturation point
    localparam int QUO_W     = CEN_W - 1;
    localparam int QUO_CNT_W = $clog2(QUO_W);

    localparam logic [CEN_W-1:0] CEN_MAX = {1'b0, {(CEN_W-1){1'b1}}};
    localparam logic [CEN_W-1:0] CEN_MIN = {1'b1, {(CEN_W-1){1'b0}}};

    // job queue between accumulator and divider
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } cdf_job_t;

    typedef struct packed {
        logic     valid;
        cdf_job_t job;
    } cdf_push_t;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_SETUP,
        DIV_CHECK,
        DIV_RUN,
        DIV_FORM,
        DIV_DONE
    } cdf_div_state_t;

endpackage

// ----- rtl/cdf_front.sv -----
module cdf_front #(
    parameter int POS_WIDTH   = 16,
    parameter int GRADE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cdf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    input  logic [cdf_pkg::QUEUE_CNT_W-1:0]   queue_count,
    output cdf_pkg::cdf_push_t                push
);
    import cdf_pkg::*;

    localparam int PROD_W  = POS_WIDTH + GRADE_WIDTH + 1;
    localparam int DX_W    = POS_WIDTH + 1;
    localparam int GSUM_W  = GRADE_WIDTH + 1;
    localparam int NTERM_W = PROD_W + 1 + DX_W;
    localparam int DTERM_W = GSUM_W + 1 + DX_W;
    localparam int COMMIT_W = QUEUE_CNT_W + 1;

    logic                          accept;
    logic signed [POS_WIDTH-1:0]   x_in;
    logic [GRADE_WIDTH-1:0]        g_in;
    logic signed [GRADE_WIDTH:0]   g_s;

    logic signed [POS_WIDTH-1:0]   prev_x_reg;
    logic [GRADE_WIDTH-1:0]        prev_g_reg;
    logic                          have_prev_reg;

    // stage a: point product, step width, grade sum
    logic                          a_valid_reg, a_last_reg, a_have_reg;
    logic signed [PROD_W-1:0]      a_prod_reg, a_prod_next;
    logic signed [DX_W-1:0]        a_dx_reg, a_dx_next;
    logic [GSUM_W-1:0]             a_gsum_reg, a_gsum_next;
    logic signed [PROD_W-1:0]      prod_prev_reg;

    // stage b: trapezoid terms
    logic                          b_valid_reg, b_last_reg, b_have_reg;
    logic signed [PROD_W:0]        psum;
    logic signed [GSUM_W:0]        gsum_s;
    logic signed [NTERM_W-1:0]     b_nterm_reg, b_nterm_next;
    logic signed [DTERM_W-1:0]     b_dterm_reg, b_dterm_next;

    // accumulators
    logic [NUM_W-1:0]              num_reg, num_next, nterm_ext;
    logic [DEN_W-1:0]              den_reg, den_next, dterm_ext;

    logic [COMMIT_W-1:0]           committed;

    assign x_in = s_tdata[POS_WIDTH-1:0];
    assign g_in = s_tdata[POS_FIELD_W +: GRADE_WIDTH];
    assign g_s  = {1'b0, g_in};

    // queue slots held by stored jobs plus run ends still in flight
    assign committed = {1'b0, queue_count}
                     + COMMIT_W'(a_valid_reg & a_last_reg)
                     + COMMIT_W'(b_valid_reg & b_last_reg);
    assign s_tready  = committed < COMMIT_W'(QUEUE_DEPTH);
    assign accept    = s_tvalid & s_tready;

    assign a_prod_next = x_in * g_s;
    assign a_dx_next   = {x_in[POS_WIDTH-1], x_in} - {prev_x_reg[POS_WIDTH-1], prev_x_reg};
    assign a_gsum_next = {1'b0, g_in} + {1'b0, prev_g_reg};

    assign psum         = {a_prod_reg[PROD_W-1], a_prod_reg}
                        + {prod_prev_reg[PROD_W-1], prod_prev_reg};
    assign gsum_s       = {1'b0, a_gsum_reg};
    assign b_nterm_next = psum * a_dx_reg;
    assign b_dterm_next = gsum_s * a_dx_reg;

    assign nterm_ext = {{(NUM_W-NTERM_W){b_nterm_reg[NTERM_W-1]}}, b_nterm_reg};
    assign dterm_ext = {{(DEN_W-DTERM_W){b_dterm_reg[DTERM_W-1]}}, b_dterm_reg};
    assign num_next  = num_reg + (b_have_reg ? nterm_ext : '0);
    assign den_next  = den_reg + (b_have_reg ? dterm_ext : '0);

    assign push.valid   = b_valid_reg & b_last_reg;
    assign push.job.num = num_next;
    assign push.job.den = den_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            num_reg       <= '0;
            den_reg       <= '0;
        end else begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (accept) begin
                have_prev_reg <= ~s_tlast;
            end
            if (b_valid_reg) begin
                if (b_last_reg) begin
                    num_reg <= '0;
                    den_reg <= '0;
                end else begin
                    num_reg <= num_next;
                    den_reg <= den_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_x_reg <= x_in;
            prev_g_reg <= g_in;
            a_last_reg <= s_tlast;
            a_have_reg <= have_prev_reg;
            a_prod_reg <= a_prod_next;
            a_dx_reg   <= a_dx_next;
            a_gsum_reg <= a_gsum_next;
        end
        if (a_valid_reg) begin
            prod_prev_reg <= a_prod_reg;
            b_last_reg    <= a_last_reg;
            b_have_reg    <= a_have_reg;
            b_nterm_reg   <= b_nterm_next;
            b_dterm_reg   <= b_dterm_next;
        end
    end

endmodule

// ----- rtl/cdf_queue.sv -----
module cdf_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cdf_pkg::cdf_push_t               push,
    output logic [cdf_pkg::QUEUE_CNT_W-1:0]  count,
    output logic                             pop_valid,
    output cdf_pkg::cdf_job_t                pop_job,
    input  logic                             pop_ready
);
    import cdf_pkg::*;

    cdf_job_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic                     pop;

    assign count     = count_reg;
    assign pop_valid = count_reg != '0;
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign pop       = pop_valid & pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push.valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// ----- rtl/cdf_div.sv -----
module cdf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    input  cdf_pkg::cdf_job_t             job,
    output logic                          job_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser
);
    import cdf_pkg::*;

    cdf_div_state_t          state_reg, state_next;

    logic [NUM_W-1:0]        num_reg;    // raw numerator, then running remainder
    logic [DEN_W-1:0]        den_reg;    // raw denominator, then its magnitude
    logic [NUM_W-1:0]        dsh_reg;
    logic [QUO_W-1:0]        q_reg;
    logic [QUO_CNT_W-1:0]    cnt_reg;
    logic                    neg_reg, zero_reg, sat_reg;
    logic [CEN_W-1:0]        cen_reg;
    logic                    undef_reg;

    logic                    sat_now;
    logic                    ge;

    assign sat_now = num_reg >= {{(NUM_W-DEN_W-QUO_W){1'b0}}, den_reg, {QUO_W{1'b0}}};
    assign ge      = num_reg >= dsh_reg;

    assign m_tdata = cen_reg;
    assign m_tuser = undef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        job_ready  = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            DIV_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    state_next = DIV_SETUP;
                end
            end
            DIV_SETUP: begin
                state_next = zero_reg ? DIV_DONE : DIV_CHECK;
            end
            DIV_CHECK: begin
                state_next = sat_now ? DIV_FORM : DIV_RUN;
            end
            DIV_RUN: begin
                if (cnt_reg == '0) begin
                    state_next = DIV_FORM;
                end
            end
            DIV_FORM: begin
                state_next = DIV_DONE;
            end
            DIV_DONE: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DIV_IDLE: begin
                num_reg  <= job.num;
                den_reg  <= job.den;
                neg_reg  <= job.num[NUM_W-1] ^ job.den[DEN_W-1];
                zero_reg <= job.den == '0;
            end
            DIV_SETUP: begin
                num_reg   <= num_reg[NUM_W-1] ? (~num_reg + 1'b1) : num_reg;
                den_reg   <= den_reg[DEN_W-1] ? (~den_reg + 1'b1) : den_reg;
                cen_reg   <= '0;
                undef_reg <= 1'b1;
            end
            DIV_CHECK: begin
                sat_reg <= sat_now;
                dsh_reg <= {{(NUM_W-DEN_W-QUO_W+1){1'b0}}, den_reg, {(QUO_W-1){1'b0}}};
                q_reg   <= '0;
                cnt_reg <= QUO_CNT_W'(QUO_W - 1);
            end
            DIV_RUN: begin
                // one restoring step per cycle, quotient msb first
                if (ge) begin
                    num_reg <= num_reg - dsh_reg;
                end
                q_reg   <= {q_reg[QUO_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            DIV_FORM: begin
                undef_reg <= 1'b0;
                if (sat_reg) begin
                    cen_reg <= neg_reg ? CEN_MIN : CEN_MAX;
                end else begin
                    cen_reg <= neg_reg ? (~{1'b0, q_reg} + 1'b1) : {1'b0, q_reg};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/centroid_defuzzifier_core.sv -----
// centroid of a sampled membership curve by the trapezoidal rule
// throughput: one curve point per cycle while the job queue has room; the divider
//   takes one run end at a time, run ends queued four deep so only runs shorter than a divide stall the input
// path: last point through stages a and b and the accumulator into the queue, then the divider
// reset: aresetn synchronous active low, clears accumulators, queue and divider
module centroid_defuzzifier_core #(
    parameter int POS_WIDTH   = 16,
    parameter int GRADE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdf_pkg::S_TDATA_W-1:0] s_tdata,   // x_pos, grade
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdf_pkg::M_TDATA_W-1:0] m_tdata,   // centroid
    output logic                          m_tuser    // undefined
);
    import cdf_pkg::*;

    cdf_push_t                push;
    logic [QUEUE_CNT_W-1:0]   queue_count;
    logic                     job_valid, job_ready;
    cdf_job_t                 job;

    cdf_front #(
        .POS_WIDTH   (POS_WIDTH),
        .GRADE_WIDTH (GRADE_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .queue_count (queue_count),
        .push        (push)
    );

    cdf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .count     (queue_count),
        .pop_valid (job_valid),
        .pop_job   (job),
        .pop_ready (job_ready)
    );

    cdf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
